@@ src/ckl_pkg.sv @@
// ckl_pkg: item types, operation and status codes for the compacting key list
`timescale 1ns / 1ps
package ckl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_BITS_DEF = 64;
  localparam int KEY_W        = 64;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 5;

  // operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_COUNT  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_COUNT     = 3'd4,
    ST_EMPTY_KEY = 3'd5
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } ckl_ctl_t;

endpackage

@@ src/compacting_key_list.sv @@
// compacting_key_list: ordered key list with append, remove-and-compact, count
//
//   channel | direction | ports                          | payload
//   --------+-----------+--------------------------------+-----------------------
//   in      | input     | in_valid, in_stall, in_data    | kind, key
//   out     | output    | out_valid, out_stall, out_data | status, count
//
// One item per cycle while in_stall is low: every cell compares its key at once,
// the first match ripples down the cell chain and later cells load from their
// neighbor in the same edge. The registered result shows the cycle after accept.
// Reset clears the fill count and the output valid; slot keys are not reset.
// in_stall follows out_stall while a result is held in the output register.
`timescale 1ns / 1ps
module compacting_key_list
  import ckl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_r;
  out_item_t           out_nxt;
  logic                take;
  logic [KEY_BITS-1:0] key_m;
  logic                key_zero;
  logic                full;
  logic                found;
  kind_t               kind;
  status_t             status;
  ckl_ctl_t            ctl;
  logic [31:0]         count_w;

  logic [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [CAPACITY:0]   hit_chain;

  // output register frees the input side as soon as it is taken
  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  assign kind     = kind_t'(in_data.kind);
  assign key_m    = in_data.key[KEY_BITS-1:0];
  assign key_zero = key_m == '0;
  assign full     = count_r == CNT_W'(CAPACITY);
  assign found    = hit_chain[CAPACITY];

  // decode the operation
  always_comb begin
    ctl       = '0;
    count_nxt = count_r;
    status    = ST_COUNT;
    unique case (kind)
      KIND_INSERT: begin
        if (key_zero) begin
          status = ST_EMPTY_KEY;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status    = ST_INSERTED;
          ctl.ins   = take;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (key_zero) begin
          status = ST_EMPTY_KEY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          status    = ST_REMOVED;
          ctl.rem   = take;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_COUNT, KIND_SPARE: begin
        status = ST_COUNT;
      end
      default: begin
        status = ST_COUNT;
      end
    endcase
  end

  // row of slot cells
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ckl_cell #(
      .IDX      (i),
      .CNT_W    (CNT_W),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .count   (count_r),
      .key     (key_m),
      .nbr_key (cell_key[(i + 1 < CAPACITY) ? i + 1 : i]),
      .hit_in  (hit_chain[i]),
      .hit_out (hit_chain[i+1]),
      .key_q   (cell_key[i])
    );
  end

  // result carries the count after the operation, modulo 32
  assign count_w = 32'(take ? count_nxt : count_r);

  always_comb begin
    out_valid_nxt  = out_valid_r & out_stall;
    out_nxt        = out_r;
    if (take) begin
      out_valid_nxt  = 1'b1;
      out_nxt.status = status;
      out_nxt.count  = count_w[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        count_r <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ src/ckl_cell.sv @@
// ckl_cell: one slot of the list, with match chain and shift from its neighbor
`timescale 1ns / 1ps
module ckl_cell
  import ckl_pkg::*;
#(
  parameter int IDX      = 0,
  parameter int CNT_W    = 5,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  ckl_ctl_t            ctl,
  input  logic [CNT_W-1:0]    count,
  input  logic [KEY_BITS-1:0] key,
  input  logic [KEY_BITS-1:0] nbr_key,
  input  logic                hit_in,
  output logic                hit_out,
  output logic [KEY_BITS-1:0] key_q
);

  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;
  logic                live;
  logic                at_tail;
  logic                shift;

  // slot position against the fill count
  assign live    = CNT_W'(IDX) < count;
  assign at_tail = CNT_W'(IDX) == count;

  // first-match chain: this slot or an earlier one holds the key
  assign hit_out = hit_in | (live & (key_r == key));
  assign shift   = ctl.rem & hit_out;

  // append at the tail or close the gap left by a removal
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins && at_tail) begin
      key_nxt = key;
    end else if (shift) begin
      key_nxt = nbr_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule
